// ===== rtl/vnl_pkg.sv =====
package vnl_pkg;

    localparam int unsigned CompW  = 32;
    localparam int unsigned RootW  = 32;
    localparam int unsigned QuoW   = 31;
    localparam int unsigned Lanes  = 3;

    typedef struct packed {
        logic [63:0]                    n;
        logic [34:0]                    rem;
        logic [RootW-1:0]               root;
        logic [Lanes-1:0][CompW-1:0]    mag;
        logic [Lanes-1:0]               neg;
    } sq_t;

    typedef struct packed {
        logic [RootW-1:0]               len;
        logic [Lanes-1:0][31:0]         rem;
        logic [Lanes-1:0][QuoW-1:0]     dvd;
        logic [Lanes-1:0][QuoW-1:0]     quo;
        logic [Lanes-1:0]               neg;
    } dv_t;

endpackage

// ===== rtl/vnl_sqrt_cell.sv =====
module vnl_sqrt_cell (
    input  logic         clk,
    input  vnl_pkg::sq_t d_in,
    output vnl_pkg::sq_t d_out
);
    import vnl_pkg::*;

    logic [34:0] rs;
    logic [34:0] trial;
    logic        ge;
    sq_t         d_next;
    sq_t         d_reg;

    always_comb
    begin
        rs     = {d_in.rem[32:0], d_in.n[63:62]};
        trial  = {1'b0, d_in.root, 2'b01};
        ge     = (rs >= trial);
        d_next = d_in;
        d_next.n = {d_in.n[61:0], 2'b00};
        if (ge)
        begin
            d_next.rem  = rs - trial;
            d_next.root = {d_in.root[RootW-2:0], 1'b1};
        end
        else
        begin
            d_next.rem  = rs;
            d_next.root = {d_in.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

// ===== rtl/vnl_div_cell.sv =====
module vnl_div_cell (
    input  logic         clk,
    input  vnl_pkg::dv_t d_in,
    output vnl_pkg::dv_t d_out
);
    import vnl_pkg::*;

    logic [Lanes-1:0][32:0] rs;
    logic [Lanes-1:0][32:0] diff;
    logic [Lanes-1:0]       ge;
    dv_t                    d_next;
    dv_t                    d_reg;

    always_comb
    begin
        d_next = d_in;
        for (int i = 0; i < Lanes; i++)
        begin
            rs[i]   = {d_in.rem[i], d_in.dvd[i][QuoW-1]};
            diff[i] = rs[i] - {1'b0, d_in.len};
            ge[i]   = (rs[i] >= {1'b0, d_in.len});
            d_next.rem[i] = ge[i] ? diff[i][31:0] : rs[i][31:0];
            d_next.dvd[i] = {d_in.dvd[i][QuoW-2:0], 1'b0};
            d_next.quo[i] = {d_in.quo[i][QuoW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

// ===== rtl/vector3_normalize_length.sv =====
// Channel   | Signals                                   | Beat taken when
// ----------+-------------------------------------------+------------------------
// command   | start, busy, comp_x, comp_y, comp_z        | start high, busy low
// result    | done, length, unit_x..unit_z, zero_length  | every cycle done is high
//
// One vector enters every cycle; busy is always low. A vector passes through the
// magnitude, square and sum stages, 32 square-root cells (one root bit each)
// and 31 divider cells (one quotient bit per lane each), then the output
// register. rst_n clears the beat-valid chain asynchronously; the datapath
// carries no reset. The receiver cannot stall, so nothing holds the pipe.
module vector3_normalize_length (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] comp_x,
    input  logic [31:0] comp_y,
    input  logic [31:0] comp_z,
    output logic        done,
    output logic [31:0] length,
    output logic [31:0] unit_x,
    output logic [31:0] unit_y,
    output logic [31:0] unit_z,
    output logic        zero_length
);
    import vnl_pkg::*;

    localparam int unsigned Lat = 3 + RootW + QuoW + 1;

    // valid bit follows each beat down the pipe
    logic [Lat-1:0] vld_reg;
    logic [Lat-1:0] vld_next;

    logic [Lanes-1:0][CompW-1:0] comp;
    logic [Lanes-1:0][CompW-1:0] mag_reg;
    logic [Lanes-1:0]            neg0_reg;
    logic [Lanes-1:0][63:0]      sq_reg;
    logic [Lanes-1:0][CompW-1:0] mag1_reg;
    logic [Lanes-1:0]            neg1_reg;
    sq_t                         sum_reg;
    sq_t                         sq_chain [RootW+1];
    dv_t                         dv_chain [QuoW+1];

    logic [31:0] len_reg;
    logic [31:0] ux_reg;
    logic [31:0] uy_reg;
    logic [31:0] uz_reg;
    logic        zero_reg;
    logic [Lanes-1:0][31:0] unit_next;
    logic        zero_next;

    assign busy = 1'b0;
    assign comp = {comp_z, comp_y, comp_x};
    assign vld_next = {vld_reg[Lat-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // magnitudes, squares, then the sum of squares
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Lanes; i++)
        begin
            mag_reg[i]  <= comp[i][31] ? (32'd0 - comp[i]) : comp[i];
            neg0_reg[i] <= comp[i][31];
            sq_reg[i]   <= {32'd0, mag_reg[i]} * {32'd0, mag_reg[i]};
        end
        mag1_reg     <= mag_reg;
        neg1_reg     <= neg0_reg;
        sum_reg.n    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        sum_reg.rem  <= '0;
        sum_reg.root <= '0;
        sum_reg.mag  <= mag1_reg;
        sum_reg.neg  <= neg1_reg;
    end

    assign sq_chain[0] = sum_reg;

    genvar g;
    generate
        for (g = 0; g < RootW; g++)
        begin : g_sqrt
            vnl_sqrt_cell u_cell (
                .clk   (clk),
                .d_in  (sq_chain[g]),
                .d_out (sq_chain[g+1])
            );
        end
    endgenerate

    // seed divider: remainder starts at mag>>1, low mag bit feeds first
    always_comb
    begin
        dv_chain[0].len = sq_chain[RootW].root;
        dv_chain[0].neg = sq_chain[RootW].neg;
        for (int i = 0; i < Lanes; i++)
        begin
            dv_chain[0].rem[i] = {1'b0, sq_chain[RootW].mag[i][31:1]};
            dv_chain[0].dvd[i] = {sq_chain[RootW].mag[i][0], {(QuoW-1){1'b0}}};
            dv_chain[0].quo[i] = '0;
        end
    end

    generate
        for (g = 0; g < QuoW; g++)
        begin : g_div
            vnl_div_cell u_cell (
                .clk   (clk),
                .d_in  (dv_chain[g]),
                .d_out (dv_chain[g+1])
            );
        end
    endgenerate

    // apply sign; drop quotients for a zero length
    always_comb
    begin
        zero_next = (dv_chain[QuoW].len == '0);
        for (int i = 0; i < Lanes; i++)
        begin
            if (zero_next)
                unit_next[i] = '0;
            else if (dv_chain[QuoW].neg[i])
                unit_next[i] = 32'd0 - {1'b0, dv_chain[QuoW].quo[i]};
            else
                unit_next[i] = {1'b0, dv_chain[QuoW].quo[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= dv_chain[QuoW].len;
        ux_reg   <= unit_next[0];
        uy_reg   <= unit_next[1];
        uz_reg   <= unit_next[2];
        zero_reg <= zero_next;
    end

    assign done        = vld_reg[Lat-1];
    assign length      = len_reg;
    assign unit_x      = ux_reg;
    assign unit_y      = uy_reg;
    assign unit_z      = uz_reg;
    assign zero_length = zero_reg;
endmodule
